// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the allocation table RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define BCAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define BCAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bcat_pkg.sv =====
// ---------------------------------------------------------------------------
// bcat_pkg
// Field widths, command and status codes and word types of the allocation
// table.
// ---------------------------------------------------------------------------
package bcat_pkg;

    localparam int CMD_W = 3;
    localparam int IDX_W = 16;
    localparam int VAL_W = 16;
    localparam int CNT_W = 11;
    localparam int RES_W = 16;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC_S = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALLOC_C = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FREE    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] block_index;
        logic [VAL_W-1:0] entry_value;
        logic [CNT_W-1:0] block_count;
    } t_cmd;

    typedef struct packed {
        logic [RES_W-1:0] result_value;
        logic [ST_W-1:0]  status;
    } t_rsp;

endpackage

// ===== hw/rtl/bcat_cmd_if.sv =====
// ---------------------------------------------------------------------------
// bcat_cmd_if
// Command channel: valid/ready handshake with the command word fields.
// ---------------------------------------------------------------------------
interface bcat_cmd_if;
    import bcat_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] block_index;
    logic [VAL_W-1:0] entry_value;
    logic [CNT_W-1:0] block_count;

    modport source (
        output valid, command, block_index, entry_value, block_count,
        input  ready
    );

    modport sink (
        input  valid, command, block_index, entry_value, block_count,
        output ready
    );

endinterface

// ===== hw/rtl/bcat_rsp_if.sv =====
// ---------------------------------------------------------------------------
// bcat_rsp_if
// Response channel: valid/ready handshake with the response word fields.
// ---------------------------------------------------------------------------
interface bcat_rsp_if;
    import bcat_pkg::*;

    logic             valid;
    logic             ready;
    logic [RES_W-1:0] result_value;
    logic [ST_W-1:0]  status;

    modport source (
        output valid, result_value, status,
        input  ready
    );

    modport sink (
        input  valid, result_value, status,
        output ready
    );

endinterface

// ===== hw/rtl/bcat_core.sv =====
// ---------------------------------------------------------------------------
// bcat_core
// Link table RAM and the command sequencer: read, write, scattered and
// contiguous allocation by streaming scans, and chain free by link walk.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bcat_core #(
    parameter int TABLE_BLOCKS = 1024,
    parameter int ENTRY_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bcat_pkg::t_cmd i_cmd,
    input  logic          i_take,
    output logic          o_idle,
    output logic          o_done,
    output bcat_pkg::t_rsp o_rsp
);
    import bcat_pkg::*;

    localparam int AW = (TABLE_BLOCKS > 1) ? $clog2(TABLE_BLOCKS) : 1;
    localparam int BW = $clog2(TABLE_BLOCKS + 1);
    localparam int CW = (ENTRY_BITS > IDX_W) ? ENTRY_BITS : IDX_W;
    localparam int SW = $clog2(TABLE_BLOCKS + 3);

    localparam logic [ENTRY_BITS-1:0] LINK_END  = '1;
    localparam logic [RES_W-1:0]      RES_END   = RES_W'(LINK_END);
    localparam logic [BW-1:0]         LAST_BLK  = BW'(TABLE_BLOCKS - 1);
    localparam logic [IDX_W-1:0]      IDX_MAX   = IDX_W'(TABLE_BLOCKS);
    localparam logic [CW-1:0]         CUR_MAX   = CW'(TABLE_BLOCKS);
    localparam logic [CW-1:0]         CUR_END   = CW'(LINK_END);
    localparam logic [SW-1:0]         STEP_LIM  = SW'(TABLE_BLOCKS + 2);
    localparam logic [AW-1:0]         ADDR_LAST = AW'(TABLE_BLOCKS - 1);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_RD_WAIT  = 4'd2;
    localparam logic [3:0] S_PREV     = 4'd3;
    localparam logic [3:0] S_SCAN     = 4'd4;
    localparam logic [3:0] S_LINK     = 4'd5;
    localparam logic [3:0] S_TERM     = 4'd6;
    localparam logic [3:0] S_HOOK     = 4'd7;
    localparam logic [3:0] S_FREE_CHK = 4'd8;
    localparam logic [3:0] S_FREE_DAT = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    // link RAM, one entry per block, block b at address b-1
    logic [ENTRY_BITS-1:0] mem [TABLE_BLOCKS];
    logic [ENTRY_BITS-1:0] r_rdata;
    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [ENTRY_BITS-1:0] wdata;

    logic [3:0]       r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_contig, n_contig;
    logic             r_prev_free, n_prev_free;
    logic [CNT_W-1:0] r_found, n_found;
    logic [CNT_W-1:0] r_linked, n_linked;
    logic [BW-1:0]    r_start, n_start;
    logic [BW-1:0]    r_last, n_last;
    logic [BW-1:0]    r_di, n_di;
    logic [CW-1:0]    r_cur, n_cur;
    logic [SW-1:0]    r_steps, n_steps;
    logic [RES_W-1:0] r_res, n_res;
    logic [ST_W-1:0]  r_st, n_st;

    logic             rd_free;
    logic             in_idx_ok;
    logic [CNT_W-1:0] scan_found;
    logic [BW-1:0]    scan_start;
    logic             link_done;
    logic             hook;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    assign rd_free    = (r_rdata == '0);
    assign in_idx_ok  = (i_cmd.block_index != '0) && (i_cmd.block_index <= IDX_MAX);
    assign scan_found = rd_free ? CNT_W'(r_found + CNT_W'(1)) : (r_contig ? '0 : r_found);
    assign scan_start = (rd_free && (r_found == '0)) ? r_di : r_start;
    assign link_done  = rd_free && (CNT_W'(r_linked + CNT_W'(1)) == r_cnt);
    // hook skipped with no previous block, or when it was free and lies inside the new run
    assign hook = (r_idx != '0) &&
                  !(r_prev_free && (r_idx >= IDX_W'(r_start)) && (r_idx <= IDX_W'(r_last)));

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_contig    = r_contig;
        n_prev_free = r_prev_free;
        n_found     = r_found;
        n_linked    = r_linked;
        n_start     = r_start;
        n_last      = r_last;
        n_di        = r_di;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_res       = r_res;
        n_st        = r_st;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        re          = 1'b0;
        raddr       = '0;

        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                n_clr = AW'(r_clr + AW'(1));
                if (r_clr == ADDR_LAST) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_start) begin
                    n_idx    = i_cmd.block_index;
                    n_cnt    = i_cmd.block_count;
                    n_contig = (i_cmd.command == CMD_ALLOC_C);
                    n_res    = '0;
                    n_st     = ST_OK;
                    case (i_cmd.command)
                        CMD_READ: begin
                            if (in_idx_ok) begin
                                re      = 1'b1;
                                raddr   = AW'(i_cmd.block_index - IDX_W'(1));
                                n_state = S_RD_WAIT;
                            end else begin
                                n_st    = ST_BAD;
                                n_state = S_DONE;
                            end
                        end
                        CMD_WRITE: begin
                            if (in_idx_ok) begin
                                we    = 1'b1;
                                waddr = AW'(i_cmd.block_index - IDX_W'(1));
                                wdata = ENTRY_BITS'(i_cmd.entry_value);
                            end else begin
                                n_st = ST_BAD;
                            end
                            n_state = S_DONE;
                        end
                        CMD_ALLOC_S, CMD_ALLOC_C: begin
                            n_res = RES_END;
                            if ((i_cmd.block_index != '0) && !in_idx_ok) begin
                                n_st    = ST_BAD;
                                n_state = S_DONE;
                            end else if (i_cmd.block_count == '0) begin
                                n_st    = ST_SHORT;
                                n_state = S_DONE;
                            end else begin
                                // fetch the previous block's entry before the scan
                                re      = (i_cmd.block_index != '0);
                                raddr   = AW'(i_cmd.block_index - IDX_W'(1));
                                n_state = S_PREV;
                            end
                        end
                        CMD_FREE: begin
                            n_cur   = CW'(i_cmd.block_index);
                            n_steps = '0;
                            n_state = S_FREE_CHK;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_RD_WAIT: begin
                n_res   = RES_W'(r_rdata);
                n_state = S_DONE;
            end

            S_PREV: begin
                n_prev_free = (r_idx != '0) && rd_free;
                re          = 1'b1;
                raddr       = '0;
                n_di        = BW'(1);
                n_found     = '0;
                n_state     = S_SCAN;
            end

            // r_rdata holds block r_di; the read of r_di+1 goes out alongside
            S_SCAN: begin
                n_found = scan_found;
                n_start = scan_start;
                if (scan_found == r_cnt) begin
                    n_last   = scan_start;
                    n_linked = CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_TERM;
                    end else begin
                        re      = 1'b1;
                        raddr   = AW'(scan_start);
                        n_di    = BW'(scan_start + BW'(1));
                        n_state = S_LINK;
                    end
                end else if (r_di == LAST_BLK) begin
                    n_st    = ST_SHORT;
                    n_state = S_DONE;
                end else begin
                    re    = 1'b1;
                    raddr = AW'(r_di);
                    n_di  = BW'(r_di + BW'(1));
                end
            end

            // writes land behind the read pointer, so no overlap
            S_LINK: begin
                if (rd_free) begin
                    we       = 1'b1;
                    waddr    = AW'(r_last - BW'(1));
                    wdata    = ENTRY_BITS'(r_di);
                    n_last   = r_di;
                    n_linked = CNT_W'(r_linked + CNT_W'(1));
                end
                if (link_done) begin
                    n_state = S_TERM;
                end else begin
                    re    = 1'b1;
                    raddr = AW'(r_di);
                    n_di  = BW'(r_di + BW'(1));
                end
            end

            S_TERM: begin
                we      = 1'b1;
                waddr   = AW'(r_last - BW'(1));
                wdata   = LINK_END;
                n_res   = RES_W'(r_start);
                n_st    = ST_OK;
                n_state = hook ? S_HOOK : S_DONE;
            end

            S_HOOK: begin
                we      = 1'b1;
                waddr   = AW'(r_idx - IDX_W'(1));
                wdata   = ENTRY_BITS'(r_start);
                n_state = S_DONE;
            end

            S_FREE_CHK: begin
                if (r_steps == STEP_LIM) begin
                    n_st    = ST_BAD;
                    n_state = S_DONE;
                end else if (r_cur == CUR_END) begin
                    n_state = S_DONE;
                end else if ((r_cur == '0) || (r_cur > CUR_MAX)) begin
                    n_st    = ST_BAD;
                    n_state = S_DONE;
                end else begin
                    re      = 1'b1;
                    raddr   = AW'(r_cur - CW'(1));
                    n_state = S_FREE_DAT;
                end
            end

            S_FREE_DAT: begin
                we      = 1'b1;
                waddr   = AW'(r_cur - CW'(1));
                wdata   = '0;
                n_cur   = CW'(r_rdata);
                n_steps = SW'(r_steps + SW'(1));
                n_state = S_FREE_CHK;
            end

            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_contig    <= n_contig;
        r_prev_free <= n_prev_free;
        r_found     <= n_found;
        r_linked    <= n_linked;
        r_start     <= n_start;
        r_last      <= n_last;
        r_di        <= n_di;
        r_cur       <= n_cur;
        r_steps     <= n_steps;
        r_res       <= n_res;
        r_st        <= n_st;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_rsp  = '{result_value: r_res, status: r_st};

    `BCAT_ASSERT_NOW(a_no_rw_clash, i_clk, i_rst_n, we && re, waddr != raddr, "RAM read and write hit the same entry")
    `BCAT_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_start, r_state == S_IDLE, "command started while busy")
    `BCAT_ASSERT_NOW(a_link_bound, i_clk, i_rst_n, r_state == S_LINK, r_linked < r_cnt, "link pass overran count")
    `BCAT_ASSERT_NOW(a_short_end, i_clk, i_rst_n, o_done && (r_st == ST_SHORT), r_res == RES_END, "short status without end marker")
    `BCAT_ASSERT_NEXT(a_done_hold, i_clk, i_rst_n, o_done && !i_take, o_done && $stable(r_res) && $stable(r_st), "result dropped before taken")

endmodule

// ===== hw/rtl/block_chain_allocation_table.sv =====
// ---------------------------------------------------------------------------
// block_chain_allocation_table
// Chained block allocation table. Commands arrive as words on i_cmd and each
// yields exactly one response word on o_rsp (result_value, status).
// After reset a clearing pass writes every entry free, and i_cmd.ready
// stays low throughout. Allocation runs a scan pass and a link pass, one
// RAM read per block each, limited by the single read port; a free reads
// then clears each entry of the chain in turn.
// One command is in flight at a time; the next is accepted once the response
// has moved into the output register, while that word still waits.
// A stalled receiver holds the response in the output register; a further
// finished response waits in the core until the register drains.
// ---------------------------------------------------------------------------
module block_chain_allocation_table #(
    parameter int TABLE_BLOCKS = 1024,
    parameter int ENTRY_BITS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bcat_cmd_if.sink        i_cmd,
    bcat_rsp_if.source      o_rsp
);
    import bcat_pkg::*;

    t_cmd cmd_word;
    t_rsp core_rsp;
    logic core_idle;
    logic core_done;
    logic start;
    logic rsp_take;
    logic r_out_valid;
    t_rsp r_out;

    assign cmd_word = '{command:     i_cmd.command,
                        block_index: i_cmd.block_index,
                        entry_value: i_cmd.entry_value,
                        block_count: i_cmd.block_count};

    assign i_cmd.ready = core_idle;
    assign start       = i_cmd.valid && core_idle;
    assign rsp_take    = core_done && (!r_out_valid || o_rsp.ready);

    bcat_core #(
        .TABLE_BLOCKS (TABLE_BLOCKS),
        .ENTRY_BITS   (ENTRY_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (cmd_word),
        .i_take  (rsp_take),
        .o_idle  (core_idle),
        .o_done  (core_done),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_take) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out.result_value;
    assign o_rsp.status       = r_out.status;

endmodule

// ===== bench/bcat_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcat_checker
// Watches the command and response channels of the allocation table. It keeps
// its own copy of the link table, works out the response word due for every
// accepted command and compares the responses with it, oldest first.
// ---------------------------------------------------------------------------
module bcat_checker #(
    parameter int TABLE_BLOCKS = 1024,
    parameter int ENTRY_BITS   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bcat_cmd_if  i_cmd,
    bcat_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import bcat_pkg::*;

    localparam int unsigned END_MARK = 32'((64'd1 << ENTRY_BITS) - 64'd1);

    typedef struct {
        t_cmd cause;
        t_rsp want;
    } t_due;

    int unsigned links [1:TABLE_BLOCKS];
    t_due        due_rsp [$];
    int          fails = 0;

    function automatic bit in_range(input int unsigned b);
        return b >= 1 && b <= TABLE_BLOCKS;
    endfunction

    function automatic logic [ST_W-1:0] alloc_run(input bit contig, input int unsigned cnt,
                                                  input int unsigned prev,
                                                  output int unsigned first);
        int unsigned start, found, last, linked, i;
        bit          prev_free;
        start = 0;
        found = 0;
        first = END_MARK;
        if (prev != 0 && !in_range(prev))
            return ST_BAD;
        if (cnt == 0)
            return ST_SHORT;
        for (i = 1; i < TABLE_BLOCKS && found < cnt; i++) begin
            if (links[i] == 0) begin
                if (found == 0)
                    start = i;
                found++;
            end else if (contig) begin
                found = 0;
            end
        end
        if (found < cnt)
            return ST_SHORT;

        prev_free = (prev != 0) && (links[prev] == 0);
        last = start;
        linked = 1;
        for (i = start + 1; i < TABLE_BLOCKS && linked < cnt; i++) begin
            if (links[i] == 0) begin
                links[last] = i;
                last = i;
                linked++;
            end
        end
        links[last] = END_MARK;
        // a free previous block swallowed by the new chain keeps its own link
        if (prev != 0 && !(prev_free && prev >= start && prev <= last))
            links[prev] = start;
        first = start;
        return ST_OK;
    endfunction

    function automatic logic [ST_W-1:0] free_run(input int unsigned start);
        int unsigned cur, nxt, steps;
        cur = start;
        for (steps = 0; steps <= TABLE_BLOCKS + 1; steps++) begin
            if (cur == END_MARK)
                return ST_OK;
            if (!in_range(cur))
                return ST_BAD;
            nxt = links[cur];
            links[cur] = 0;
            cur = nxt;
        end
        return ST_BAD;
    endfunction

    function automatic t_rsp apply_cmd(input t_cmd w);
        t_rsp        r;
        int unsigned first;
        r.result_value = '0;
        r.status = ST_OK;
        case (w.command)
            CMD_READ: begin
                if (in_range(w.block_index))
                    r.result_value = RES_W'(links[w.block_index]);
                else
                    r.status = ST_BAD;
            end
            CMD_WRITE: begin
                if (in_range(w.block_index))
                    links[w.block_index] = 32'(w.entry_value) & END_MARK;
                else
                    r.status = ST_BAD;
            end
            CMD_ALLOC_S, CMD_ALLOC_C: begin
                r.status = alloc_run(w.command == CMD_ALLOC_C, w.block_count,
                                     w.block_index, first);
                r.result_value = RES_W'(first);
            end
            CMD_FREE: r.status = free_run(w.block_index);
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_due head;
        t_cmd word;
        if (!i_rst_n) begin
            foreach (links[b])
                links[b] = 0;
            due_rsp.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_rsp.size() == 0) begin
                    fails++;
                    $display("%0t: response word with none due: result_value %h status %0d",
                             $time, i_rsp.result_value, i_rsp.status);
                end else begin
                    head = due_rsp.pop_front();
                    if (i_rsp.result_value !== head.want.result_value) begin
                        fails++;
                        $display("%0t: result_value (cmd %0d idx %0d cnt %0d): exp %h act %h",
                                 $time, head.cause.command, head.cause.block_index,
                                 head.cause.block_count, head.want.result_value,
                                 i_rsp.result_value);
                    end
                    if (i_rsp.status !== head.want.status) begin
                        fails++;
                        $display("%0t: status (cmd %0d idx %0d cnt %0d): exp %0d act %0d",
                                 $time, head.cause.command, head.cause.block_index,
                                 head.cause.block_count, head.want.status, i_rsp.status);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                word.command     = i_cmd.command;
                word.block_index = i_cmd.block_index;
                word.entry_value = i_cmd.entry_value;
                word.block_count = i_cmd.block_count;
                head.cause = word;
                head.want  = apply_cmd(word);
                due_rsp.push_back(head);
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_rsp.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives the allocation table with a directed run over the corner cases and
// then random command words, mostly allocations and frees of chains it has
// seen allocated. Both handshakes idle at random; a checker beside the block
// predicts and compares every response word.
// ---------------------------------------------------------------------------
module tb;
    import bcat_pkg::*;

    localparam int TABLE_BLOCKS = 1024;
    localparam int ENTRY_BITS   = 16;
    localparam int ITEMS        = 290;

    localparam logic [VAL_W-1:0] LINK_FREE = '0;
    localparam logic [VAL_W-1:0] LINK_END  = '1;
    localparam logic [CMD_W-1:0] CMD_SPARE = CMD_FREE + 1'b1;

    typedef struct {
        int unsigned head;
        int unsigned len;
    } t_chain;

    typedef struct {
        t_cmd word;
        bit   tracked;
        bit   hooked;
    } t_sent;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    int     fail_count;
    int     pending;
    bit     cmd_burst;
    bit     rsp_burst;
    t_chain chains [$];
    t_sent  sent [$];

    bcat_cmd_if cmd_ch ();
    bcat_rsp_if rsp_ch ();

    block_chain_allocation_table #(
        .TABLE_BLOCKS (TABLE_BLOCKS),
        .ENTRY_BITS   (ENTRY_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    bcat_checker #(
        .TABLE_BLOCKS (TABLE_BLOCKS),
        .ENTRY_BITS   (ENTRY_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic t_cmd make_word(input logic [CMD_W-1:0] c, input int unsigned idx,
                                       input int unsigned val, input int unsigned cnt);
        t_cmd w;
        w.command     = c;
        w.block_index = IDX_W'(idx);
        w.entry_value = VAL_W'(val);
        w.block_count = CNT_W'(cnt);
        return w;
    endfunction

    task automatic send(input t_cmd w, input bit tracked, input bit hooked);
        int    gap;
        t_sent s;
        gap = cmd_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 15) == 0)
            cmd_burst = !cmd_burst;
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.command     <= w.command;
        cmd_ch.block_index <= w.block_index;
        cmd_ch.entry_value <= w.entry_value;
        cmd_ch.block_count <= w.block_count;
        cmd_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!cmd_ch.ready);
        s.word = w;
        s.tracked = tracked;
        s.hooked = hooked;
        sent.push_back(s);
        @(negedge i_clk);
    endtask

    task automatic direct(input logic [CMD_W-1:0] c, input int unsigned idx,
                          input int unsigned val, input int unsigned cnt);
        send(make_word(c, idx, val, cnt), 1'b0, 1'b0);
    endtask

    // Mostly allocations and frees of known chain heads; the rest reads,
    // writes, stray frees and spare command codes.
    task automatic make_random(output t_cmd w, output bit hooked);
        int pick, r, j;
        hooked = 1'b0;
        w = make_word(CMD_READ, 0, $urandom_range(0, 65535), $urandom_range(0, 2047));
        pick = $urandom_range(0, 99);
        if (chains.size() > 24 && pick < 40)
            pick = 50;
        if (pick >= 36 && pick < 64 && chains.size() == 0)
            pick = 0;
        if (pick < 36) begin
            w.command = ($urandom_range(0, 1) != 0) ? CMD_ALLOC_C : CMD_ALLOC_S;
            r = $urandom_range(0, 99);
            if (r < 70)
                w.block_count = CNT_W'($urandom_range(1, 8));
            else if (r < 85)
                w.block_count = CNT_W'($urandom_range(9, 64));
            else if (r < 90)
                w.block_count = '0;
            else if (r < 95)
                w.block_count = CNT_W'($urandom_range(65, TABLE_BLOCKS - 1));
            else
                w.block_count = CNT_W'($urandom_range(TABLE_BLOCKS, (1 << CNT_W) - 1));
            w.block_index = '0;
            r = $urandom_range(0, 99);
            if (r < 25) begin
                // hook only after a lone block, whose link is known to be end
                for (j = 0; j < chains.size(); j++) begin
                    if (chains[j].len == 1) begin
                        w.block_index = IDX_W'(chains[j].head);
                        chains.delete(j);
                        hooked = 1'b1;
                        break;
                    end
                end
            end else if (r < 28) begin
                w.block_index = IDX_W'($urandom_range(TABLE_BLOCKS + 1, 65535));
            end
        end else if (pick < 64) begin
            j = $urandom_range(0, chains.size() - 1);
            w.command = CMD_FREE;
            w.block_index = IDX_W'(chains[j].head);
            chains.delete(j);
        end else if (pick < 78) begin
            w.block_index = ($urandom_range(0, 9) != 0) ?
                            IDX_W'($urandom_range(1, TABLE_BLOCKS)) :
                            IDX_W'($urandom_range(0, 65535));
        end else if (pick < 88) begin
            w.command = CMD_WRITE;
            r = $urandom_range(0, 3);
            if (r == 0)
                w.block_index = '0;
            else if (r == 1)
                w.block_index = IDX_W'($urandom_range(TABLE_BLOCKS + 1, 65535));
            else
                w.block_index = IDX_W'(TABLE_BLOCKS);
        end else if (pick < 91) begin
            w.command = CMD_WRITE;
            w.block_index = IDX_W'($urandom_range(1, TABLE_BLOCKS));
        end else if (pick < 94) begin
            w.command = CMD_FREE;
            w.block_index = ($urandom_range(0, 1) != 0) ?
                            IDX_W'($urandom_range(1, TABLE_BLOCKS)) :
                            IDX_W'($urandom_range(0, 65535));
        end else begin
            w.command = CMD_W'($urandom_range(CMD_SPARE, (1 << CMD_W) - 1));
        end
    endtask

    // receiver: random stalls, and chain heads noted from the words it takes
    initial begin
        t_sent s;
        t_chain c;
        int    stall;
        wait (i_rst_n);
        forever begin
            stall = rsp_burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0)
                rsp_burst = !rsp_burst;
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            if (sent.size() != 0) begin
                s = sent.pop_front();
                if (s.tracked && (s.word.command == CMD_ALLOC_S ||
                                  s.word.command == CMD_ALLOC_C)) begin
                    if (s.hooked) begin
                        c.head = s.word.block_index;
                        c.len = (rsp_ch.status == ST_OK) ? 1 + s.word.block_count : 1;
                        chains.push_back(c);
                    end else if (rsp_ch.status == ST_OK) begin
                        c.head = rsp_ch.result_value;
                        c.len = s.word.block_count;
                        chains.push_back(c);
                    end
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        t_cmd w;
        bit   hooked;
        int   counted;
        int   waited;
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_READ;
        cmd_ch.block_index = '0;
        cmd_ch.entry_value = '0;
        cmd_ch.block_count = '0;
        rsp_ch.ready       = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        direct(CMD_READ, 0, 0, 0);
        direct(CMD_WRITE, 65535, 16'h1234, 0);
        direct(CMD_ALLOC_S, 0, 0, 0);
        direct(CMD_ALLOC_C, TABLE_BLOCKS + 1, 0, 3);
        direct(CMD_ALLOC_S, 0, 0, TABLE_BLOCKS - 1);
        direct(CMD_ALLOC_S, 0, 0, 1);
        direct(CMD_WRITE, TABLE_BLOCKS, LINK_END, 0);
        direct(CMD_READ, TABLE_BLOCKS, 0, 0);
        direct(CMD_FREE, 1, 0, 0);
        // chain 1..4, then a link broken by an out-of-range value
        direct(CMD_ALLOC_S, 0, 0, 4);
        direct(CMD_WRITE, 2, 16'h5A5A, 0);
        direct(CMD_FREE, 1, 0, 0);
        direct(CMD_WRITE, 3, LINK_FREE, 0);
        direct(CMD_FREE, 4, 0, 0);
        // contiguous search has to skip a taken block; hook after a used block
        direct(CMD_ALLOC_C, 0, 0, 3);
        direct(CMD_WRITE, 5, 7, 0);
        direct(CMD_ALLOC_C, 1, 0, 3);
        // previous block free and taken into the new chain
        direct(CMD_ALLOC_S, 4, 0, 2);
        direct(CMD_FREE, 1, 0, 0);
        direct(CMD_FREE, 5, 0, 0);
        direct(CMD_FREE, LINK_END, 0, 0);
        direct(CMD_FREE, 0, 0, 0);
        direct(CMD_FREE, 4, 0, 0);
        send(make_word('1, 65535, 65535, (1 << CNT_W) - 1), 1'b0, 1'b0);
        direct(CMD_ALLOC_C, 0, 65535, (1 << CNT_W) - 1);

        counted = 0;
        while (counted < ITEMS) begin
            make_random(w, hooked);
            send(w, 1'b1, hooked);
            counted++;
        end
        cmd_ch.valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (64) @(posedge i_clk);
        if (pending != 0)
            $display("%0t: %0d response words never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bcat_pkg.sv
hw/rtl/bcat_cmd_if.sv
hw/rtl/bcat_rsp_if.sv
hw/rtl/bcat_core.sv
hw/rtl/block_chain_allocation_table.sv
bench/bcat_checker.sv
bench/tb.sv
